// ===== design/decimal_format_printer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal format printer
// Shared helpers for the concurrent checks in the design modules.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_FORMAT_PRINTER_UNIT_ASSERT_SVH
`define DECIMAL_FORMAT_PRINTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/dfp_pkg.sv =====
// ----------------------------------------------------------------------------
// dfp_pkg
// Constants and shared types for the decimal format printer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfp_pkg;

  // Width of the integer argument actually used (at most the port width).
  localparam int ARG_WIDTH  = 32;
  localparam int ARG_PORT_W = 32;

  // Decimal digits needed for an ARG_WIDTH-bit magnitude.
  localparam int NUM_DIGITS = (ARG_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(ARG_WIDTH + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;

  localparam logic [3:0] DABBLE_LIMIT = 4'd5;
  localparam logic [3:0] DABBLE_ADJ   = 4'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } dabble_status_t;

endpackage

// ===== design/dfp_dabble.sv =====
// ----------------------------------------------------------------------------
// dfp_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "decimal_format_printer_unit_assert.svh"

module dfp_dabble
  import dfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ARG_WIDTH-1:0] mag,
  output dabble_status_t       stat,
  output logic [BCD_W-1:0]     bcd
);

  logic [ARG_WIDTH-1:0] mag_sh;
  logic [BCD_W-1:0]     bcd_adj;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 busy;
  logic                 done;

  // Each digit is corrected on its own before the shift.
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] >= DABBLE_LIMIT) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + DABBLE_ADJ;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= BIT_CNT_W'(ARG_WIDTH);
      end else if (busy) begin
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == BIT_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_sh <= mag;
      bcd    <= '0;
    end else if (busy) begin
      mag_sh <= {mag_sh[ARG_WIDTH-2:0], 1'b0};
      bcd    <= {bcd_adj[BCD_W-2:0], mag_sh[ARG_WIDTH-1]};
    end
  end

  assign stat = '{busy: busy, done: done};

  `DFP_ASSERT_IMPL(a_start_idle, clk, rst, start, !busy)
  `DFP_ASSERT_IMPL(a_busy_count, clk, rst, busy, bit_cnt != '0)
  `DFP_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

endmodule

// ===== design/decimal_format_printer_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_format_printer_unit
// Format-string printer for signed decimal directives (%d, %i).
// ----------------------------------------------------------------------------
// Takes one format character per transaction. A NUL, or a percent sign that
// opens a directive, gives no output; an echoed character is placed in the
// output register. A %d or %i directive runs a bit-serial binary to BCD
// conversion of the ARG_WIDTH (32) magnitude bits, then scans the NUM_DIGITS
// (10) BCD digits one per cycle, skipping leading zeros, while each digit to
// print waits until the output register is free. A new transaction is taken
// only when no directive is in progress and the output register is free or
// being emptied in the same cycle.
`timescale 1ns / 1ps
`include "decimal_format_printer_unit_assert.svh"

module decimal_format_printer_unit
  import dfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            fmt_char,
  input  logic signed [ARG_PORT_W-1:0] arg_value,
  input  logic                  new_format,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t               state, state_next;
  logic                 percent_pending, percent_pending_next;
  logic                 out_valid_next;
  logic [7:0]           out_char_next;
  logic                 out_last_next;
  logic [BCD_W-1:0]     dig_sh, dig_sh_next;
  logic [DIG_CNT_W-1:0] dig_cnt, dig_cnt_next;
  logic                 started, started_next;

  logic                 out_free;
  logic                 pend;
  logic                 is_dir;
  logic [ARG_WIDTH-1:0] arg_v;
  logic                 arg_neg;
  logic [ARG_WIDTH-1:0] arg_mag;
  logic [3:0]           top_dig;
  logic                 conv_start;
  dabble_status_t       conv_stat;
  logic [BCD_W-1:0]     conv_bcd;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign pend     = percent_pending && !new_format;
  assign is_dir   = (fmt_char == CH_D) || (fmt_char == CH_I);
  assign arg_v    = arg_value[ARG_WIDTH-1:0];
  assign arg_neg  = arg_v[ARG_WIDTH-1];
  // Two's complement negate; the most negative value maps to its magnitude.
  assign arg_mag  = arg_neg ? (~arg_v + 1'b1) : arg_v;
  assign top_dig  = dig_sh[BCD_W-1 -: 4];

  dfp_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .mag   (arg_mag),
    .stat  (conv_stat),
    .bcd   (conv_bcd)
  );

  always_comb begin
    state_next           = state;
    percent_pending_next = percent_pending;
    out_valid_next       = out_valid && !out_ready;
    out_char_next        = out_char;
    out_last_next        = out_last;
    dig_sh_next          = dig_sh;
    dig_cnt_next         = dig_cnt;
    started_next         = started;
    conv_start           = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          priority if (fmt_char == CH_NUL) begin
            percent_pending_next = 1'b0;
          end else if (pend) begin
            percent_pending_next = 1'b0;
            if (is_dir) begin
              conv_start = 1'b1;
              state_next = S_CONV;
              if (arg_neg) begin
                out_valid_next = 1'b1;
                out_char_next  = CH_MINUS;
                out_last_next  = 1'b0;
              end
            end else begin
              out_valid_next = 1'b1;
              out_char_next  = fmt_char;
              out_last_next  = 1'b1;
            end
          end else if (fmt_char == CH_PERCENT) begin
            percent_pending_next = 1'b1;
          end else begin
            // A new format string drops a held percent before the echo.
            percent_pending_next = 1'b0;
            out_valid_next       = 1'b1;
            out_char_next        = fmt_char;
            out_last_next        = 1'b1;
          end
        end
      end
      S_CONV: begin
        if (conv_stat.done) begin
          dig_sh_next  = conv_bcd;
          dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
          started_next = 1'b0;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        // Leading zeros are dropped, but the final digit always prints.
        priority if (!started && (top_dig == 4'd0) && (dig_cnt != DIG_CNT_W'(1))) begin
          dig_sh_next  = {dig_sh[BCD_W-5:0], 4'd0};
          dig_cnt_next = dig_cnt - 1'b1;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = CH_ZERO + {4'd0, top_dig};
          out_last_next  = (dig_cnt == DIG_CNT_W'(1));
          dig_sh_next    = {dig_sh[BCD_W-5:0], 4'd0};
          dig_cnt_next   = dig_cnt - 1'b1;
          started_next   = 1'b1;
          if (dig_cnt == DIG_CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      percent_pending <= 1'b0;
      out_valid       <= 1'b0;
      dig_cnt         <= '0;
      started         <= 1'b0;
    end else begin
      state           <= state_next;
      percent_pending <= percent_pending_next;
      out_valid       <= out_valid_next;
      dig_cnt         <= dig_cnt_next;
      started         <= started_next;
    end
  end

  always_ff @(posedge clk) begin
    out_char <= out_char_next;
    out_last <= out_last_next;
    dig_sh   <= dig_sh_next;
  end

  `DFP_ASSERT_IMPL(a_done_in_conv, clk, rst, conv_stat.done, state == S_CONV)
  `DFP_ASSERT_IMPL(a_emit_count, clk, rst, state == S_EMIT, dig_cnt != '0)
  `DFP_ASSERT_NEXT(a_echo_out, clk, rst,
    in_valid && in_ready && (fmt_char != CH_NUL) && !pend && (fmt_char != CH_PERCENT),
    out_valid && out_last)

endmodule

// ===== verif/decimal_format_printer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// decimal_format_printer_unit_tb
// Self-checking bench for the signed decimal format printer. A queue of
// format characters drives the input channel, and every accepted transaction
// is run through a behavioral printer that queues the characters it should
// emit. The output channel is checked in order against that queue, with
// random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_format_printer_unit_tb;
  import dfp_pkg::*;

  localparam int NUM_ITEMS          = 170;
  localparam int IDLE_PERCENT       = 17;
  localparam int QUIET_START        = 1500;
  localparam int QUIET_END          = 3000;
  localparam int DRAIN_CYCLES       = 60;
  localparam int STALL_LIMIT        = 2000;

  typedef struct {
    logic [7:0]                  ch;
    logic signed [ARG_PORT_W-1:0] arg;
    logic                        nf;
  } fmt_item_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } print_char_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   fmt_char = '0;
  logic signed [ARG_PORT_W-1:0] arg_value = '0;
  logic                         new_format = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [7:0]                   out_char;
  logic                         out_last;

  fmt_item_t   format_items_q[$];
  print_char_t printed_chars_q[$];
  logic        percent_held = 1'b0;
  int          queued_items = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          stall_cycles = 0;

  decimal_format_printer_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fmt_char   (fmt_char),
    .arg_value  (arg_value),
    .new_format (new_format),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .out_last   (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idling stops entirely inside one window so back-to-back traffic is seen.
  function automatic logic take_break();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_END) return 1'b0;
    return $urandom_range(99) < IDLE_PERCENT;
  endfunction

  function automatic void push_char(logic [7:0] ch, logic last);
    print_char_t pc;
    pc.ch   = ch;
    pc.last = last;
    printed_chars_q.push_back(pc);
  endfunction

  // Behavioral printer: updates the held-percent flag and queues the text
  // that one format character should produce.
  function automatic void print_format_char(fmt_item_t it);
    logic signed [ARG_WIDTH-1:0] used;
    logic [63:0]                 wide;
    logic [63:0]                 mag;
    logic [7:0]                  digits[$];
    logic                        directive;
    if (it.nf) percent_held = 1'b0;
    if (it.ch == CH_NUL) begin
      percent_held = 1'b0;
      return;
    end
    directive = percent_held && (it.ch == CH_D || it.ch == CH_I);
    if (!percent_held && it.ch == CH_PERCENT) begin
      percent_held = 1'b1;
      return;
    end
    percent_held = 1'b0;
    if (!directive) begin
      push_char(it.ch, 1'b1);
      return;
    end
    used = it.arg[ARG_WIDTH-1:0];
    wide = 64'(used);
    // The magnitude is taken as unsigned so the most negative value works.
    mag = used[ARG_WIDTH-1] ? (~wide + 64'd1) : wide;
    if (ARG_WIDTH < 64) mag = mag & ((64'd1 << ARG_WIDTH) - 64'd1);
    do begin
      digits.push_front(CH_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (used[ARG_WIDTH-1]) push_char(CH_MINUS, 1'b0);
    foreach (digits[k]) push_char(digits[k], k == digits.size() - 1);
  endfunction

  function automatic void add_item(logic [7:0] ch, logic signed [ARG_PORT_W-1:0] arg,
                                   logic nf);
    fmt_item_t it;
    it.ch  = ch;
    it.arg = arg;
    it.nf  = nf;
    format_items_q.push_back(it);
    queued_items++;
  endfunction

  function automatic logic signed [ARG_PORT_W-1:0] pick_arg();
    logic signed [ARG_PORT_W-1:0] a;
    case ($urandom_range(5))
      0: a = ARG_PORT_W'($urandom_range(9));
      1: a = ARG_PORT_W'($urandom_range(99999));
      2: begin
        case ($urandom_range(3))
          0: a = {1'b1, {(ARG_PORT_W-1){1'b0}}};
          1: a = {1'b0, {(ARG_PORT_W-1){1'b1}}};
          2: a = '1;
          default: a = '0;
        endcase
      end
      default: a = ARG_PORT_W'($urandom);
    endcase
    if ($urandom_range(1)) a = -a;
    return a;
  endfunction

  function automatic logic [7:0] pick_plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_PERCENT) c = "_";
    return c;
  endfunction

  // Stimulus: directed cases first, then mostly well-formed format strings.
  initial begin
    int  segs;
    logic first;
    add_item("H", pick_arg(), 1'b1);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_D, '0, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_I, {1'b1, {(ARG_PORT_W-1){1'b0}}}, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_D, {1'b0, {(ARG_PORT_W-1){1'b1}}}, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_I, '1, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_PERCENT, '1, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item("x", 32'sd5, 1'b0);
    // A trailing percent is dropped when the next string starts.
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_D, 32'sd77, 1'b1);
    // A NUL also drops a held percent.
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_NUL, '1, 1'b0);
    add_item(CH_I, 32'sd3, 1'b0);
    add_item(8'hFF, '1, 1'b0);
    add_item(CH_D, 32'sd9, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_D, 32'sd10, 1'b0);
    add_item(CH_PERCENT, '0, 1'b0);
    add_item(CH_PERCENT, '0, 1'b1);
    add_item(CH_D, 32'sd1000000000, 1'b0);
    add_item(CH_NUL, '0, 1'b0);

    while (queued_items < NUM_ITEMS) begin
      if ($urandom_range(9) < 8) begin
        segs  = $urandom_range(1, 6);
        first = 1'b1;
        repeat (segs) begin
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
              add_item(CH_PERCENT, ARG_PORT_W'($urandom), first);
              add_item($urandom_range(1) ? CH_D : CH_I, pick_arg(), 1'b0);
            end
            6, 7, 8: add_item(pick_plain_char(), ARG_PORT_W'($urandom), first);
            default: begin
              add_item(CH_PERCENT, ARG_PORT_W'($urandom), first);
              add_item(8'($urandom_range(1, 255)), pick_arg(), 1'b0);
            end
          endcase
          first = 1'b0;
        end
        if ($urandom_range(1)) add_item(CH_NUL, ARG_PORT_W'($urandom), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          add_item(8'($urandom_range(255)), ARG_PORT_W'($urandom), 1'(
                   $urandom_range(1)));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (format_items_q.size() != 0 || in_valid || printed_chars_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Input driver: a transaction is predicted at the edge that accepts it.
  always @(posedge clk) begin
    fmt_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it.ch  = fmt_char;
        it.arg = arg_value;
        it.nf  = new_format;
        print_format_char(it);
      end
      if (!in_valid || in_ready) begin
        if (format_items_q.size() != 0 && !take_break()) begin
          it = format_items_q.pop_front();
          fmt_char   <= it.ch;
          arg_value  <= it.arg;
          new_format <= it.nf;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random back-pressure.
  always @(posedge clk) begin
    print_char_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (printed_chars_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected output char 8'h%02h last %0b", $time, out_char,
                   out_last);
        end else begin
          want = printed_chars_q.pop_front();
          if (out_char !== want.ch) begin
            error_count++;
            $display("%0t: out_char expected 8'h%02h actual 8'h%02h", $time, want.ch,
                     out_char);
          end
          if (out_last !== want.last) begin
            error_count++;
            $display("%0t: out_last expected %0b actual %0b", $time, want.last,
                     out_last);
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // Watchdog: a long run of cycles with no transaction on either side.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
+incdir+design
design/dfp_pkg.sv
design/dfp_dabble.sv
design/decimal_format_printer_unit.sv
verif/decimal_format_printer_unit_tb.sv
